FILE: rtl/rmsg_pkg.sv
// Shared types and constants for the metal/roughness to specular/gloss pixel converter.
// Used by rmsg_pipe and roughness_metal_to_spec_gloss_pixel; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rmsg_pkg;

   // Byte-wide pixel channels and register fields
   localparam int BYTE_W     = 8;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register reset values
   localparam logic [BYTE_W-1:0] OCCLUSION_STRENGTH_RESET  = 8'd255;
   localparam logic [BYTE_W-1:0] DIELECTRIC_SPECULAR_RESET = 8'd10;

   // Register index, taken from the word address
   typedef enum logic [0:0] {
      CSR_OCCLUSION_STRENGTH  = 1'b0,
      CSR_DIELECTRIC_SPECULAR = 1'b1
   } csr_reg_type;

   // Pipeline control from the handshake logic
   typedef struct packed {
      logic advance;   // every stage loads this cycle
      logic in_valid;  // a transaction enters stage one
   } rmsg_ctrl_type;

endpackage

`default_nettype wire

FILE: rtl/rmsg_pipe.sv
// Five-stage fixed-point datapath of the pixel converter.
// Depends on rmsg_pkg for the control struct and byte width.
`timescale 1ns / 1ps
`default_nettype none

module rmsg_pipe #(
   parameter int FRAC_BITS = 16
) (
   input  wire                         clock,
   input  wire                         reset,
   input  rmsg_pkg::rmsg_ctrl_type     ctrl,
   input  wire  [rmsg_pkg::BYTE_W-1:0] base_red,
   input  wire  [rmsg_pkg::BYTE_W-1:0] base_green,
   input  wire  [rmsg_pkg::BYTE_W-1:0] base_blue,
   input  wire  [rmsg_pkg::BYTE_W-1:0] roughness_level,
   input  wire  [rmsg_pkg::BYTE_W-1:0] metal_level,
   input  wire  [rmsg_pkg::BYTE_W-1:0] occlusion_level,
   input  wire  [rmsg_pkg::BYTE_W-1:0] occlusion_strength,
   input  wire  [rmsg_pkg::BYTE_W-1:0] dielectric_specular,
   output logic                        out_valid,
   output logic [rmsg_pkg::BYTE_W-1:0] diffuse_red,
   output logic [rmsg_pkg::BYTE_W-1:0] diffuse_green,
   output logic [rmsg_pkg::BYTE_W-1:0] diffuse_blue,
   output logic [rmsg_pkg::BYTE_W-1:0] specular_red,
   output logic [rmsg_pkg::BYTE_W-1:0] specular_green,
   output logic [rmsg_pkg::BYTE_W-1:0] specular_blue,
   output logic [rmsg_pkg::BYTE_W-1:0] glossiness
);
   import rmsg_pkg::*;

   localparam int STAGES = 5;
   localparam int FW     = FRAC_BITS + 1;      // fraction in [0, ONE]
   localparam int PW     = 2 * FW;             // full product
   localparam int MW     = FRAC_BITS + 9;      // reciprocal of 255
   localparam int CSH    = 16;                 // reciprocal scale beyond FRAC_BITS
   localparam logic [FW-1:0] ONE = FW'(1) << FRAC_BITS;
   localparam logic [FW-1:0] C004 = FW'(((64'd1 << FRAC_BITS) * 64'd4) / 64'd100);
   localparam logic [63:0] RECIP64 =
      ((64'd1 << (FRAC_BITS + CSH)) + 64'd254) / 64'd255;
   localparam logic [MW-1:0] RECIP = RECIP64[MW-1:0];

   // byte/255 as a fraction: exact floor through a scaled reciprocal
   function automatic logic [FW-1:0] to_fx(input logic [BYTE_W-1:0] b);
      logic [MW+BYTE_W-1:0] p;
      p = {{MW{1'b0}}, b} * {{BYTE_W{1'b0}}, RECIP};
      return p[CSH +: FW];
   endfunction

   // Fraction product, truncated
   function automatic logic [FW-1:0] fx_mul(input logic [FW-1:0] a,
                                            input logic [FW-1:0] b);
      logic [PW-1:0] p;
      p = {{FW{1'b0}}, a} * {{FW{1'b0}}, b};
      return p[FRAC_BITS +: FW];
   endfunction

   // Fraction to byte: times 255 by shift and subtract, truncate, clamp
   function automatic logic [BYTE_W-1:0] fx_to_byte(input logic [FW-1:0] v);
      logic [FW+BYTE_W-1:0] t;
      logic [BYTE_W:0]      r;
      t = {v, {BYTE_W{1'b0}}} - {{BYTE_W{1'b0}}, v};
      r = t[FRAC_BITS +: BYTE_W+1];
      return r[BYTE_W] ? {BYTE_W{1'b1}} : r[BYTE_W-1:0];
   endfunction

   // Clamp a sum of fractions to ONE
   function automatic logic [FW-1:0] clamp_one(input logic [FW:0] s);
      return (s > {1'b0, ONE}) ? ONE : s[FW-1:0];
   endfunction

   logic [STAGES-1:0] valid_ff, valid_in;

   // Stage 1: byte conversion
   logic [FW-1:0] rough1_ff, rough1_in, metal1_ff, metal1_in, occ1_ff, occ1_in;
   logic [FW-1:0] istr1_ff, istr1_in, bspec1_ff, bspec1_in;
   logic [FW-1:0] col1_ff [3];
   logic [FW-1:0] col1_in [3];
   // Stage 2: gloss, weakened occlusion, color products
   logic [FW-1:0] gloss2_ff, gloss2_in, ao2_ff, ao2_in;
   logic [PW-1:0] pa2_ff, pa2_in;
   logic [FW-1:0] cm2_ff [3];
   logic [FW-1:0] cm2_in [3];
   logic [PW-1:0] pb2_ff [3];
   logic [PW-1:0] pb2_in [3];
   // Stage 3: gloss squared, diffuse, specular mix
   logic [FW-1:0] g2_3_ff, g2_3_in, ao3_ff, ao3_in;
   logic [BYTE_W-1:0] gbyte3_ff, gbyte3_in;
   logic [FW-1:0] diff3_ff [3];
   logic [FW-1:0] diff3_in [3];
   logic [FW-1:0] mix3_ff [3];
   logic [FW-1:0] mix3_in [3];
   // Stage 4: specular occlusion, diffuse bytes
   logic [FW-1:0] sao4_ff, sao4_in;
   logic [BYTE_W-1:0] gbyte4_ff, gbyte4_in;
   logic [BYTE_W-1:0] dbyte4_ff [3];
   logic [BYTE_W-1:0] dbyte4_in [3];
   logic [FW-1:0] mix4_ff [3];
   logic [FW-1:0] mix4_in [3];
   // Stage 5: output bytes
   logic [BYTE_W-1:0] gbyte5_ff, gbyte5_in;
   logic [BYTE_W-1:0] dbyte5_ff [3];
   logic [BYTE_W-1:0] dbyte5_in [3];
   logic [BYTE_W-1:0] sbyte5_ff [3];
   logic [BYTE_W-1:0] sbyte5_in [3];

   // Advance valid bits with the data
   assign valid_in = {valid_ff[STAGES-2:0], ctrl.in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctrl.advance) begin
         valid_ff <= valid_in;
      end
   end

   // Stage 1: convert bytes to fractions
   always_comb begin
      rough1_in  = to_fx(roughness_level);
      metal1_in  = to_fx(metal_level);
      occ1_in    = to_fx(occlusion_level);
      istr1_in   = ONE - to_fx(occlusion_strength);
      bspec1_in  = to_fx(dielectric_specular);
      col1_in[0] = to_fx(base_red);
      col1_in[1] = to_fx(base_green);
      col1_in[2] = to_fx(base_blue);
   end

   // Stage 2: gloss, occlusion, per-channel products
   always_comb begin
      logic [FW-1:0] imetal;
      logic [FW:0]   ao_sum;
      imetal    = ONE - metal1_ff;
      gloss2_in = (ONE - rough1_ff) + fx_mul(C004, rough1_ff);
      ao_sum    = {1'b0, occ1_ff} + {1'b0, fx_mul(ONE - occ1_ff, istr1_ff)};
      ao2_in    = clamp_one(ao_sum);
      pa2_in    = {{FW{1'b0}}, bspec1_ff} * {{FW{1'b0}}, imetal};
      for (int ch = 0; ch < 3; ch++) begin
         cm2_in[ch] = fx_mul(col1_ff[ch], imetal);
         pb2_in[ch] = {{FW{1'b0}}, col1_ff[ch]} * {{FW{1'b0}}, metal1_ff};
      end
   end

   // Stage 3: square gloss, apply occlusion to diffuse, sum specular mix
   always_comb begin
      logic [PW:0] mix_sum;
      mix_sum   = '0;
      g2_3_in   = fx_mul(gloss2_ff, gloss2_ff);
      ao3_in    = ao2_ff;
      gbyte3_in = fx_to_byte(gloss2_ff);
      for (int ch = 0; ch < 3; ch++) begin
         diff3_in[ch] = fx_mul(cm2_ff[ch], ao2_ff);
         mix_sum      = {1'b0, pa2_ff} + {1'b0, pb2_ff[ch]};
         mix3_in[ch]  = mix_sum[FRAC_BITS +: FW];
      end
   end

   // Stage 4: specular occlusion, diffuse to bytes
   always_comb begin
      logic [FW:0] sao_sum;
      sao_sum   = {1'b0, g2_3_ff} + {1'b0, fx_mul(ao3_ff, ONE - g2_3_ff)};
      sao4_in   = clamp_one(sao_sum);
      gbyte4_in = gbyte3_ff;
      for (int ch = 0; ch < 3; ch++) begin
         dbyte4_in[ch] = fx_to_byte(diff3_ff[ch]);
         mix4_in[ch]   = mix3_ff[ch];
      end
   end

   // Stage 5: specular color to bytes
   always_comb begin
      gbyte5_in = gbyte4_ff;
      for (int ch = 0; ch < 3; ch++) begin
         dbyte5_in[ch] = dbyte4_ff[ch];
         sbyte5_in[ch] = fx_to_byte(fx_mul(mix4_ff[ch], sao4_ff));
      end
   end

   // Payload registers: load on advance, hold on stall
   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         rough1_ff <= rough1_in;
         metal1_ff <= metal1_in;
         occ1_ff   <= occ1_in;
         istr1_ff  <= istr1_in;
         bspec1_ff <= bspec1_in;
         gloss2_ff <= gloss2_in;
         ao2_ff    <= ao2_in;
         pa2_ff    <= pa2_in;
         g2_3_ff   <= g2_3_in;
         ao3_ff    <= ao3_in;
         gbyte3_ff <= gbyte3_in;
         sao4_ff   <= sao4_in;
         gbyte4_ff <= gbyte4_in;
         gbyte5_ff <= gbyte5_in;
         for (int ch = 0; ch < 3; ch++) begin
            col1_ff[ch]   <= col1_in[ch];
            cm2_ff[ch]    <= cm2_in[ch];
            pb2_ff[ch]    <= pb2_in[ch];
            diff3_ff[ch]  <= diff3_in[ch];
            mix3_ff[ch]   <= mix3_in[ch];
            dbyte4_ff[ch] <= dbyte4_in[ch];
            mix4_ff[ch]   <= mix4_in[ch];
            dbyte5_ff[ch] <= dbyte5_in[ch];
            sbyte5_ff[ch] <= sbyte5_in[ch];
         end
      end
   end

   // Last stage drives the result
   assign out_valid      = valid_ff[STAGES-1];
   assign diffuse_red    = dbyte5_ff[0];
   assign diffuse_green  = dbyte5_ff[1];
   assign diffuse_blue   = dbyte5_ff[2];
   assign specular_red   = sbyte5_ff[0];
   assign specular_green = sbyte5_ff[1];
   assign specular_blue  = sbyte5_ff[2];
   assign glossiness     = gbyte5_ff;

endmodule

`default_nettype wire

FILE: rtl/roughness_metal_to_spec_gloss_pixel.sv
// Converts one metal/roughness pixel per cycle into diffuse, specular and gloss bytes.
// A pixel transaction entering on req_ passes the five register stages of rmsg_pipe
// and is delivered on rsp_ when rsp_ready is high; a new pixel is taken every cycle
// unless the pipeline holds. While rsp_ready is low with a result waiting, the whole
// pipeline holds and req_ready drops. Registers: occlusion_strength at byte address
// 0, dielectric_specular at 4; write them only while the pipeline is empty.
// Depends on rmsg_pkg and rmsg_pipe.
`timescale 1ns / 1ps
`default_nettype none

module roughness_metal_to_spec_gloss_pixel #(
   parameter int FRAC_BITS = 16
) (
   input  wire                              clock,
   input  wire                              reset,
   // Pixel input
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire  [rmsg_pkg::BYTE_W-1:0]      req_base_red,
   input  wire  [rmsg_pkg::BYTE_W-1:0]      req_base_green,
   input  wire  [rmsg_pkg::BYTE_W-1:0]      req_base_blue,
   input  wire  [rmsg_pkg::BYTE_W-1:0]      req_roughness_level,
   input  wire  [rmsg_pkg::BYTE_W-1:0]      req_metal_level,
   input  wire  [rmsg_pkg::BYTE_W-1:0]      req_occlusion_level,
   // Result
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output logic [rmsg_pkg::BYTE_W-1:0]      rsp_diffuse_red,
   output logic [rmsg_pkg::BYTE_W-1:0]      rsp_diffuse_green,
   output logic [rmsg_pkg::BYTE_W-1:0]      rsp_diffuse_blue,
   output logic [rmsg_pkg::BYTE_W-1:0]      rsp_specular_red,
   output logic [rmsg_pkg::BYTE_W-1:0]      rsp_specular_green,
   output logic [rmsg_pkg::BYTE_W-1:0]      rsp_specular_blue,
   output logic [rmsg_pkg::BYTE_W-1:0]      rsp_glossiness,
   // Register port
   input  wire                              csr_psel,
   input  wire                              csr_penable,
   input  wire                              csr_pwrite,
   input  wire  [rmsg_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire  [rmsg_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [rmsg_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import rmsg_pkg::*;

   logic [BYTE_W-1:0] occ_strength_ff, occ_strength_in;
   logic [BYTE_W-1:0] diel_spec_ff, diel_spec_in;
   logic              csr_write;
   csr_reg_type       csr_sel;
   rmsg_ctrl_type     ctrl;

   // Decode the register from the word address
   assign csr_sel    = csr_reg_type'(csr_paddr[2]);
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // Register write
   always_comb begin
      occ_strength_in = occ_strength_ff;
      diel_spec_in    = diel_spec_ff;
      if (csr_write) begin
         case (csr_sel)
            CSR_OCCLUSION_STRENGTH:  occ_strength_in = csr_pwdata[BYTE_W-1:0];
            CSR_DIELECTRIC_SPECULAR: diel_spec_in    = csr_pwdata[BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_strength_ff <= OCCLUSION_STRENGTH_RESET;
         diel_spec_ff    <= DIELECTRIC_SPECULAR_RESET;
      end else begin
         occ_strength_ff <= occ_strength_in;
         diel_spec_ff    <= diel_spec_in;
      end
   end

   // Register read
   always_comb begin
      case (csr_sel)
         CSR_OCCLUSION_STRENGTH:  csr_prdata = {{(CSR_DATA_W-BYTE_W){1'b0}}, occ_strength_ff};
         CSR_DIELECTRIC_SPECULAR: csr_prdata = {{(CSR_DATA_W-BYTE_W){1'b0}}, diel_spec_ff};
         default:                 csr_prdata = '0;
      endcase
   end

   // Advance the pipeline unless a finished result is held back
   assign ctrl.advance  = ~rsp_valid | rsp_ready;
   assign ctrl.in_valid = req_valid;
   assign req_ready     = ctrl.advance;

   rmsg_pipe #(
      .FRAC_BITS (FRAC_BITS)
   ) u_pipe (
      .clock               (clock),
      .reset               (reset),
      .ctrl                (ctrl),
      .base_red            (req_base_red),
      .base_green          (req_base_green),
      .base_blue           (req_base_blue),
      .roughness_level     (req_roughness_level),
      .metal_level         (req_metal_level),
      .occlusion_level     (req_occlusion_level),
      .occlusion_strength  (occ_strength_ff),
      .dielectric_specular (diel_spec_ff),
      .out_valid           (rsp_valid),
      .diffuse_red         (rsp_diffuse_red),
      .diffuse_green       (rsp_diffuse_green),
      .diffuse_blue        (rsp_diffuse_blue),
      .specular_red        (rsp_specular_red),
      .specular_green      (rsp_specular_green),
      .specular_blue       (rsp_specular_blue),
      .glossiness          (rsp_glossiness)
   );

endmodule

`default_nettype wire
